FILE: design/qpsg_pkg.sv
// Package with the shared types, constants and arithmetic helpers of the quadrant glyph block.
package qpsg_pkg;

  localparam int unsigned ColorWidth = 24;
  localparam int unsigned CfgIdxWidth = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxWidth-1:0] RegKeyEnable = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegKeyColor  = 2'd1;

  // Glyph codes.
  localparam logic [7:0] GlyphSpace = 8'd32;
  localparam logic [7:0] GlyphNone  = 8'd0;
  localparam logic [7:0] Glyph226   = 8'd226;
  localparam logic [7:0] Glyph227   = 8'd227;
  localparam logic [7:0] Glyph228   = 8'd228;
  localparam logic [7:0] Glyph229   = 8'd229;
  localparam logic [7:0] Glyph230   = 8'd230;
  localparam logic [7:0] Glyph231   = 8'd231;
  localparam logic [7:0] Glyph232   = 8'd232;

  // What a merge step does with the incoming pixel.
  typedef enum logic [2:0] {
    ActSkip,
    ActJoin0,
    ActJoin1,
    ActBlend0,
    ActBlend1,
    ActMerge
  } act_e;

  // Two-colour palette state carried down the pipeline.
  typedef struct packed {
    logic                  single;
    logic [1:0]            first;
    logic [ColorWidth-1:0] pal0;
    logic [ColorWidth-1:0] pal1;
    logic [1:0]            w0;
    logic [1:0]            w1;
    logic [2:0]            mask;
    logic [ColorWidth-1:0] px2;
    logic [ColorWidth-1:0] px3;
  } pal_t;

  function automatic logic [17:0] dist2(input logic [23:0] a, input logic [23:0] b);
    logic [17:0] sum;
    logic [7:0]  d;
    sum = '0;
    for (int s = 0; s < 3; s++) begin
      d = (a[s*8 +: 8] > b[s*8 +: 8]) ? (a[s*8 +: 8] - b[s*8 +: 8])
                                      : (b[s*8 +: 8] - a[s*8 +: 8]);
      sum = sum + {2'b00, 16'(d * d)};
    end
    return sum;
  endfunction

  // floor((a*(q-p) + b*p) / q) per channel; q is 2 or 3 here.
  function automatic logic [23:0] blend(input logic [23:0] a, input logic [23:0] b,
                                        input logic [1:0] p, input logic [1:0] q);
    logic [23:0] r;
    logic [9:0]  x;
    logic [20:0] prod;
    logic [1:0]  qp;
    r  = '0;
    qp = q - p;
    for (int s = 0; s < 3; s++) begin
      x = 10'(a[s*8 +: 8] * qp) + 10'(b[s*8 +: 8] * p);
      prod = {11'd0, x} * 21'd683;
      if (q == 2'd2) begin
        r[s*8 +: 8] = x[8:1];
      end else begin
        r[s*8 +: 8] = prod[18:11];
      end
    end
    return r;
  endfunction

endpackage

FILE: design/quad_pixel_to_subcell_glyph.sv
// Top level of the 2x2 pixel block to two-colour quadrant glyph quantizer.
//
// Usage: drive the four pixels, the cell background and the two edge flags
// and raise start_i for one cycle per block. busy_o is always low: the block
// is a six-stage pipeline that takes one beat in every clock cycle.
// Each result is shown on the result ports for exactly one cycle with done_o
// high. Results leave in start order.
// The receiver cannot stall; none is needed as nothing ever waits.
// Stage one replaces keyed and missing pixels and finds the first pixel that
// differs from the top-left one. Stages two and three fold the bottom-left
// pixel into the palette: distances first, then the blend. Stages four and
// five do the same for the bottom-right pixel. Stage six maps the mask to a
// glyph and orders the colours. Throughput is one block per cycle.
// The configuration port writes key_enable (index 0) and key_color (index 1);
// other indexes are ignored. Write it only while no block is in flight.
// Reset clears the key registers and valid flags, emptying the pipeline.
module quad_pixel_to_subcell_glyph
  import qpsg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [ColorWidth-1:0]  cfg_data_i,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [ColorWidth-1:0]  pix_top_left_i,
  input  logic [ColorWidth-1:0]  pix_top_right_i,
  input  logic [ColorWidth-1:0]  pix_bottom_left_i,
  input  logic [ColorWidth-1:0]  pix_bottom_right_i,
  input  logic [ColorWidth-1:0]  cell_background_i,
  input  logic                   has_right_i,
  input  logic                   has_below_i,
  output logic                   done_o,
  output logic                   single_color_o,
  output logic [ColorWidth-1:0]  back_color_o,
  output logic [ColorWidth-1:0]  fore_color_o,
  output logic [7:0]             glyph_o
);

  logic                  key_en_q;
  logic [ColorWidth-1:0] key_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_en_q  <= 1'b0;
      key_col_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKeyEnable: key_en_q  <= cfg_data_i[0];
        RegKeyColor:  key_col_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // Stage one: substitution and palette start.
  logic [ColorWidth-1:0] px [4];
  logic [3:0]            present;
  pal_t                  s1_d, s1_q;
  logic [4:0]            vld_q;

  always_comb begin
    present = {has_right_i & has_below_i, has_below_i, has_right_i, 1'b1};
    px[0] = pix_top_left_i;
    px[1] = pix_top_right_i;
    px[2] = pix_bottom_left_i;
    px[3] = pix_bottom_right_i;
    for (int k = 0; k < 4; k++) begin
      if (!present[k] || (key_en_q && px[k] == key_col_q)) begin
        px[k] = cell_background_i;
      end
    end
    s1_d        = '0;
    s1_d.pal0   = px[0];
    s1_d.px2    = px[2];
    s1_d.px3    = px[3];
    s1_d.w1     = 2'd1;
    if (px[1] != px[0]) begin
      s1_d.first = 2'd1;
      s1_d.pal1  = px[1];
      s1_d.w0    = 2'd1;
      s1_d.mask  = 3'b001;
    end else if (px[2] != px[0]) begin
      s1_d.first = 2'd2;
      s1_d.pal1  = px[2];
      s1_d.w0    = 2'd2;
      s1_d.mask  = 3'b010;
    end else if (px[3] != px[0]) begin
      s1_d.first = 2'd3;
      s1_d.pal1  = px[3];
      s1_d.w0    = 2'd3;
      s1_d.mask  = 3'b100;
    end else begin
      s1_d.single = 1'b1;
      s1_d.first  = 2'd3;
      s1_d.pal1   = px[0];
    end
  end

  // Decide what the pixel at position pos does to the palette.
  function automatic act_e decide(input pal_t st, input logic [ColorWidth-1:0] c,
                                  input logic [1:0] pos);
    logic [17:0] d0, d1, d01;
    act_e        a;
    d0  = dist2(c, st.pal0);
    d1  = dist2(c, st.pal1);
    d01 = dist2(st.pal0, st.pal1);
    if (st.single || st.first >= pos) begin
      a = ActSkip;
    end else if (c == st.pal0) begin
      a = ActJoin0;
    end else if (c == st.pal1) begin
      a = ActJoin1;
    end else if (d0 < d1 && d0 <= d01) begin
      a = ActBlend0;
    end else if (d0 >= d1 && d1 <= d01) begin
      a = ActBlend1;
    end else begin
      a = ActMerge;
    end
    return a;
  endfunction

  function automatic pal_t apply(input pal_t st, input logic [ColorWidth-1:0] c,
                                 input act_e a, input logic [2:0] bitm);
    pal_t r;
    r = st;
    case (a)
      ActJoin0: r.w0 = st.w0 + 2'd1;
      ActJoin1: begin
        r.w1   = st.w1 + 2'd1;
        r.mask = st.mask | bitm;
      end
      ActBlend0: begin
        r.pal0 = blend(c, st.pal0, st.w0, st.w0 + 2'd1);
        r.w0   = st.w0 + 2'd1;
      end
      ActBlend1: begin
        r.pal1 = blend(c, st.pal1, st.w1, st.w1 + 2'd1);
        r.w1   = st.w1 + 2'd1;
        r.mask = st.mask | bitm;
      end
      ActMerge: begin
        r.pal0 = blend(st.pal0, st.pal1, st.w1, st.w0 + st.w1);
        r.w0   = st.w0 + 2'd1;
        r.pal1 = c;
        r.mask = bitm;
      end
      default: ;
    endcase
    return r;
  endfunction

  pal_t s2_q, s3_d, s3_q, s4_q, s5_d, s5_q;
  act_e a2_d, a2_q, a4_d, a4_q;

  assign a2_d = decide(s1_q, s1_q.px2, 2'd2);
  assign s3_d = apply(s2_q, s2_q.px2, a2_q, 3'b010);
  assign a4_d = decide(s3_q, s3_q.px3, 2'd3);
  assign s5_d = apply(s4_q, s4_q.px3, a4_q, 3'b100);

  // Stage six: glyph lookup and colour order.
  logic                  single_d;
  logic [ColorWidth-1:0] back_d, fore_d;
  logic [7:0]            glyph_d;
  logic                  swap;

  always_comb begin
    swap    = 1'b0;
    glyph_d = GlyphNone;
    unique case (s5_q.mask)
      3'd1: glyph_d = Glyph227;
      3'd2: glyph_d = Glyph232;
      3'd3: begin glyph_d = Glyph230; swap = 1'b1; end
      3'd4: glyph_d = Glyph229;
      3'd5: glyph_d = Glyph231;
      3'd6: begin glyph_d = Glyph228; swap = 1'b1; end
      3'd7: begin glyph_d = Glyph226; swap = 1'b1; end
      default: glyph_d = GlyphNone;
    endcase
    single_d = s5_q.single;
    back_d   = swap ? s5_q.pal1 : s5_q.pal0;
    fore_d   = swap ? s5_q.pal0 : s5_q.pal1;
    if (s5_q.single) begin
      glyph_d = GlyphSpace;
      back_d  = s5_q.pal0;
      fore_d  = s5_q.pal0;
    end
  end

  logic                  done_q, single_q;
  logic [ColorWidth-1:0] back_q, fore_q;
  logic [7:0]            glyph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[3:0], start_i};
      done_q <= vld_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q     <= s1_d;
    s2_q     <= s1_q;
    a2_q     <= a2_d;
    s3_q     <= s3_d;
    s4_q     <= s3_q;
    a4_q     <= a4_d;
    s5_q     <= s5_d;
    single_q <= single_d;
    back_q   <= back_d;
    fore_q   <= fore_d;
    glyph_q  <= glyph_d;
  end

  assign done_o         = done_q;
  assign single_color_o = single_q;
  assign back_color_o   = back_q;
  assign fore_color_o   = fore_q;
  assign glyph_o        = glyph_q;

endmodule
